// ===== rtl/lhbp_pkg.sv =====
// lhbp_pkg: types and fixed constants of the local history branch predictor
// used by lhbp_if, lhbp_ctrl, lhbp_dp and the top level
`default_nettype none

package lhbp_pkg;

    localparam int PC_W        = 16;
    localparam int CFG_W       = 5;
    localparam int HIST_W      = 3;
    localparam int CTR_W       = 3;
    localparam int NUM_CTRS    = 8;
    localparam int MISS_W      = 16;
    localparam int ENTRY_OUT_W = 4;

    localparam logic [CFG_W-1:0]  CFG_RESET     = 5'd1;
    localparam logic [CTR_W-1:0]  CTR_MAX       = 3'd7;
    localparam logic [CTR_W-1:0]  CTR_MIN       = 3'd0;
    localparam logic [CTR_W-1:0]  CTR_TAKEN_MIN = 3'd4;
    localparam logic [MISS_W-1:0] MISS_MAX      = 16'hFFFF;

    // remainder unit retires this many index bits per cycle
    localparam int DIV_BITS   = 4;
    localparam int DIV_CYCLES = PC_W / DIV_BITS;
    localparam int STEP_W     = $clog2(DIV_CYCLES);

    typedef struct packed {
        logic [MISS_W-1:0]                miss;
        logic [NUM_CTRS-1:0][CTR_W-1:0]   ctrs;
        logic [HIST_W-1:0]                hist;
    } t_entry;

    typedef struct packed {
        logic clr;
        logic load;
        logic div_step;
        logic rd;
        logic upd;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic div_last;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

// ===== rtl/lhbp_if.sv =====
// lhbp_if: valid/ready channel interfaces for items, results and configuration
// depends on lhbp_pkg for field widths
`default_nettype none

interface lhbp_in_if;
    logic                           valid;
    logic                           ready;
    logic [lhbp_pkg::PC_W-1:0]      pc_index;
    logic                           taken;

    modport source (output valid, output pc_index, output taken, input ready);
    modport sink   (input valid, input pc_index, input taken, output ready);
endinterface

interface lhbp_out_if;
    logic                              valid;
    logic                              ready;
    logic [lhbp_pkg::ENTRY_OUT_W-1:0]  entry_used;
    logic                              predicted_taken;
    logic                              mispredicted;
    logic [lhbp_pkg::MISS_W-1:0]       entry_misses;

    modport source (output valid, output entry_used, output predicted_taken,
                    output mispredicted, output entry_misses, input ready);
    modport sink   (input valid, input entry_used, input predicted_taken,
                    input mispredicted, input entry_misses, output ready);
endinterface

interface lhbp_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [lhbp_pkg::CFG_W-1:0]     entries_in_use;

    modport source (output valid, output entries_in_use, input ready);
    modport sink   (input valid, input entries_in_use, output ready);
endinterface

`default_nettype wire

// ===== rtl/lhbp_ctrl.sv =====
// lhbp_ctrl: sequencer of the predictor, clear pass, remainder, read, update
// depends on lhbp_pkg for the command and status structs
`default_nettype none

module lhbp_ctrl (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    input  wire lhbp_pkg::t_sts   i_sts,
    output lhbp_pkg::t_cmd        o_cmd
);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_DIV   = 5'b00100,
        S_READ  = 5'b01000,
        S_UPD   = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) n_state = S_READ;
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_UPD;
            end
            S_UPD: begin
                if (i_sts.out_free) begin
                    o_cmd.upd = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/lhbp_dp.sv =====
// lhbp_dp: datapath with config register, remainder unit, entry memory, output register
// depends on lhbp_pkg for widths, constants and structs
`default_nettype none

module lhbp_dp #(
    parameter int NUM_ENTRIES = 16
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire lhbp_pkg::t_cmd                i_cmd,
    output lhbp_pkg::t_sts                     o_sts,
    input  wire                                i_cfg_we,
    input  wire [lhbp_pkg::CFG_W-1:0]          i_cfg_data,
    input  wire [lhbp_pkg::PC_W-1:0]           i_pc_index,
    input  wire                                i_taken,
    input  wire                                i_out_ready,
    output logic                               o_out_valid,
    output logic [lhbp_pkg::ENTRY_OUT_W-1:0]   o_entry_used,
    output logic                               o_predicted_taken,
    output logic                               o_mispredicted,
    output logic [lhbp_pkg::MISS_W-1:0]        o_entry_misses
);

    localparam int W_CNT = $clog2(NUM_ENTRIES + 1);
    localparam int W_IDX = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

    logic [lhbp_pkg::CFG_W-1:0]      r_cfg;
    logic [lhbp_pkg::PC_W-1:0]       r_pc;
    logic                            r_taken;
    logic [W_CNT-1:0]                r_div;
    logic [W_CNT-1:0]                r_rem;
    logic [lhbp_pkg::STEP_W-1:0]     r_step;
    logic [W_IDX-1:0]                r_clr_addr;
    lhbp_pkg::t_entry                r_rd;
    lhbp_pkg::t_entry                mem [NUM_ENTRIES];

    logic [W_CNT-1:0]                w_div;
    logic [W_CNT-1:0]                w_rem_nxt;
    logic [lhbp_pkg::PC_W-1:0]       w_pc_nxt;
    logic [W_IDX-1:0]                w_idx;
    logic [lhbp_pkg::CTR_W-1:0]      w_ctr;
    logic                            w_pred;
    logic                            w_miss;
    lhbp_pkg::t_entry                w_new;

    // active entry count, zero acts as one, clamp at the array size
    always_comb begin
        if (r_cfg == '0) begin
            w_div = W_CNT'(1);
        end else if (32'(r_cfg) > 32'(NUM_ENTRIES)) begin
            w_div = W_CNT'(NUM_ENTRIES);
        end else begin
            w_div = W_CNT'(r_cfg);
        end
    end

    // restoring remainder, msb first
    always_comb begin
        logic [W_CNT:0]              t;
        logic [lhbp_pkg::PC_W-1:0]   p;
        t = {1'b0, r_rem};
        p = r_pc;
        for (int k = 0; k < lhbp_pkg::DIV_BITS; k++) begin
            t = {t[W_CNT-1:0], p[lhbp_pkg::PC_W-1]};
            p = {p[lhbp_pkg::PC_W-2:0], 1'b0};
            if (t >= {1'b0, r_div}) t = t - {1'b0, r_div};
        end
        w_rem_nxt = t[W_CNT-1:0];
        w_pc_nxt  = p;
    end

    assign w_idx = r_rem[W_IDX-1:0];

    // prediction and entry update
    always_comb begin
        w_ctr  = r_rd.ctrs[r_rd.hist];
        w_pred = (w_ctr >= lhbp_pkg::CTR_TAKEN_MIN);
        w_miss = (w_pred != r_taken);
        w_new  = r_rd;
        if (w_miss && (r_rd.miss != lhbp_pkg::MISS_MAX)) begin
            w_new.miss = r_rd.miss + lhbp_pkg::MISS_W'(1);
        end
        if (r_taken) begin
            if (w_ctr != lhbp_pkg::CTR_MAX) begin
                w_new.ctrs[r_rd.hist] = w_ctr + lhbp_pkg::CTR_W'(1);
            end
        end else begin
            if (w_ctr != lhbp_pkg::CTR_MIN) begin
                w_new.ctrs[r_rd.hist] = w_ctr - lhbp_pkg::CTR_W'(1);
            end
        end
        w_new.hist = {r_rd.hist[lhbp_pkg::HIST_W-2:0], r_taken};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= lhbp_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            r_cfg <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step     <= '0;
            r_clr_addr <= '0;
        end else begin
            if (i_cmd.load) begin
                r_step <= '0;
            end else if (i_cmd.div_step) begin
                r_step <= r_step + lhbp_pkg::STEP_W'(1);
            end
            if (i_cmd.clr) r_clr_addr <= r_clr_addr + W_IDX'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pc    <= i_pc_index;
            r_taken <= i_taken;
            r_div   <= w_div;
            r_rem   <= '0;
        end else if (i_cmd.div_step) begin
            r_pc  <= w_pc_nxt;
            r_rem <= w_rem_nxt;
        end
    end

    // entry memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            mem[r_clr_addr] <= '0;
        end else if (i_cmd.upd) begin
            mem[w_idx] <= w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) r_rd <= mem[w_idx];
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.upd) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd) begin
            o_entry_used      <= lhbp_pkg::ENTRY_OUT_W'(w_idx);
            o_predicted_taken <= w_pred;
            o_mispredicted    <= w_miss;
            o_entry_misses    <= w_new.miss;
        end
    end

    assign o_sts.clr_last = (r_clr_addr == W_IDX'(NUM_ENTRIES - 1));
    assign o_sts.div_last = (r_step == lhbp_pkg::STEP_W'(lhbp_pkg::DIV_CYCLES - 1));
    assign o_sts.out_free = !o_out_valid || i_out_ready;

endmodule

`default_nettype wire

// ===== rtl/local_history_branch_predictor_core.sv =====
// local_history_branch_predictor_core: top level, joins lhbp_ctrl and lhbp_dp
// depends on lhbp_pkg and the channel interfaces in lhbp_if
//
//  channel  dir  handshake      payload
//  i_in     in   valid/ready    pc_index[15:0], taken
//  o_out    out  valid/ready    entry_used[3:0], predicted_taken, mispredicted,
//                               entry_misses[15:0]
//  i_cfg    in   valid/ready    entries_in_use[4:0], ready always high
//
// an item goes from accept through the remainder steps (4 index bits a cycle),
// entry read, update and write back
// after reset a clearing pass zeroes every entry of the entry memory,
// no item is accepted during it
// a result waits in the output register; the next item is accepted meanwhile and
// holds in its update cycle until the output register frees
`default_nettype none

module local_history_branch_predictor_core #(
    parameter int NUM_ENTRIES = 16
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    lhbp_in_if.sink        i_in,
    lhbp_cfg_if.sink       i_cfg,
    lhbp_out_if.source     o_out
);

    lhbp_pkg::t_cmd w_cmd;
    lhbp_pkg::t_sts w_sts;
    logic           w_in_ready;

    assign i_in.ready  = w_in_ready;
    assign i_cfg.ready = 1'b1;

    lhbp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    lhbp_dp #(
        .NUM_ENTRIES (NUM_ENTRIES)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_cfg_we          (i_cfg.valid),
        .i_cfg_data        (i_cfg.entries_in_use),
        .i_pc_index        (i_in.pc_index),
        .i_taken           (i_in.taken),
        .i_out_ready       (o_out.ready),
        .o_out_valid       (o_out.valid),
        .o_entry_used      (o_out.entry_used),
        .o_predicted_taken (o_out.predicted_taken),
        .o_mispredicted    (o_out.mispredicted),
        .o_entry_misses    (o_out.entry_misses)
    );

`ifndef SYNTHESIS
    a_out_from_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(w_cmd.upd))
        else $error("result appeared without an update");

    a_upd_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.upd |-> w_sts.out_free)
        else $error("update while output register is occupied");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && w_in_ready) |=> !w_in_ready)
        else $error("item accepted while previous item in flight");

    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.clr, w_cmd.load, w_cmd.div_step, w_cmd.rd, w_cmd.upd}))
        else $error("conflicting datapath commands");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// testbench: self-checking bench for local_history_branch_predictor_core
// depends on lhbp_pkg and the channel interfaces in lhbp_if; a built-in predictor
// checks every result while the entry count setting moves through its range
`default_nettype none

module testbench;

    localparam int N_ENTRIES    = 16;
    localparam int PHASE_ITEMS  = 220;
    localparam int SETTLE_CYC   = 10;
    localparam int IDLE_LIMIT   = 2000;
    localparam int OPPOSE_ITEMS = 40;

    typedef struct {
        logic [lhbp_pkg::PC_W-1:0] pc;
        logic                      taken;
        bit                        oppose;
    } t_branch;

    typedef struct packed {
        logic [lhbp_pkg::ENTRY_OUT_W-1:0] entry;
        logic                             pred;
        logic                             miss;
        logic [lhbp_pkg::MISS_W-1:0]      misses;
    } t_outcome;

    logic i_clk;
    logic i_rst_n;

    lhbp_in_if  br_ch ();
    lhbp_cfg_if cfg_ch ();
    lhbp_out_if res_ch ();

    local_history_branch_predictor_core #(
        .NUM_ENTRIES(N_ENTRIES)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (br_ch),
        .i_cfg   (cfg_ch),
        .o_out   (res_ch)
    );

    // predictor state
    logic [lhbp_pkg::CFG_W-1:0]  cfg_shadow;
    logic [lhbp_pkg::HIST_W-1:0] hist_mem [N_ENTRIES];
    logic [lhbp_pkg::CTR_W-1:0]  ctr_mem  [N_ENTRIES][lhbp_pkg::NUM_CTRS];
    logic [lhbp_pkg::MISS_W-1:0] miss_mem [N_ENTRIES];

    t_branch  pending_q [$];
    t_outcome outcome_q [$];

    int  n_fail;
    int  n_items;
    int  n_results;
    int  n_misses;
    int  n_cfg;
    int  burst_left;
    int  gap_left;
    int  idle_cycles;
    bit  no_idle;
    logic [7:0] ready_mask;
    int  mask_left;
    int  mask_pos;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned entry_of(input logic [lhbp_pkg::PC_W-1:0] pc);
        int unsigned n;
        n = 32'(cfg_shadow);
        if (n == 0)
            n = 1;
        if (n > N_ENTRIES)
            n = N_ENTRIES;
        return pc % n;
    endfunction

    function automatic t_outcome resolve_branch(input logic [lhbp_pkg::PC_W-1:0] pc,
                                                input logic tk);
        t_outcome     r;
        int unsigned  e;
        logic [lhbp_pkg::HIST_W-1:0] h;
        logic [lhbp_pkg::CTR_W-1:0]  c;
        e = entry_of(pc);
        h = hist_mem[e];
        c = ctr_mem[e][h];
        r.entry = lhbp_pkg::ENTRY_OUT_W'(e);
        r.pred  = (c >= lhbp_pkg::CTR_TAKEN_MIN);
        r.miss  = (r.pred != tk);
        if (r.miss && miss_mem[e] != lhbp_pkg::MISS_MAX)
            miss_mem[e] = miss_mem[e] + lhbp_pkg::MISS_W'(1);
        if (tk && c != lhbp_pkg::CTR_MAX)
            c = c + lhbp_pkg::CTR_W'(1);
        else if (!tk && c != lhbp_pkg::CTR_MIN)
            c = c - lhbp_pkg::CTR_W'(1);
        ctr_mem[e][h] = c;
        hist_mem[e]   = {h[lhbp_pkg::HIST_W-2:0], tk};
        r.misses      = miss_mem[e];
        return r;
    endfunction

    // driver: bursts of items with random gaps
    always @(posedge i_clk) begin
        t_branch     nxt;
        t_outcome    fresh;
        int unsigned e;
        if (!i_rst_n) begin
            br_ch.valid    <= 1'b0;
            br_ch.pc_index <= '0;
            br_ch.taken    <= 1'b0;
            burst_left     = 0;
            gap_left       = 0;
        end else begin
            if (br_ch.valid && br_ch.ready) begin
                fresh     = resolve_branch(br_ch.pc_index, br_ch.taken);
                outcome_q = {outcome_q, fresh};
                n_items++;
            end
            if (!br_ch.valid || br_ch.ready) begin
                if (gap_left > 0 && !no_idle) begin
                    gap_left--;
                    br_ch.valid <= 1'b0;
                end else if (pending_q.size() == 0) begin
                    br_ch.valid <= 1'b0;
                end else begin
                    nxt = pending_q.pop_front();
                    if (nxt.oppose) begin
                        // force a misprediction on the entry's current counter
                        e = entry_of(nxt.pc);
                        nxt.taken = !(ctr_mem[e][hist_mem[e]] >= lhbp_pkg::CTR_TAKEN_MIN);
                    end
                    br_ch.valid    <= 1'b1;
                    br_ch.pc_index <= nxt.pc;
                    br_ch.taken    <= nxt.taken;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150)
                                                                 : $urandom_range(1, 16);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end
            end
        end
    end

    // monitor: checks each result, stalls on a rotating ready mask
    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            ready_mask   = 8'hFF;
            mask_left    = 0;
            mask_pos     = 0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                n_results++;
                if (outcome_q.size() == 0) begin
                    $error("result with no prediction pending: entry_used %0d",
                           res_ch.entry_used);
                    n_fail++;
                end else begin
                    want = outcome_q.pop_front();
                    if (want.miss)
                        n_misses++;
                    if (res_ch.entry_used !== want.entry) begin
                        $error("entry_used: expected %0d, got %0d",
                               want.entry, res_ch.entry_used);
                        n_fail++;
                    end
                    if (res_ch.predicted_taken !== want.pred) begin
                        $error("predicted_taken: expected %0d, got %0d",
                               want.pred, res_ch.predicted_taken);
                        n_fail++;
                    end
                    if (res_ch.mispredicted !== want.miss) begin
                        $error("mispredicted: expected %0d, got %0d",
                               want.miss, res_ch.mispredicted);
                        n_fail++;
                    end
                    if (res_ch.entry_misses !== want.misses) begin
                        $error("entry_misses: expected %0d, got %0d",
                               want.misses, res_ch.entry_misses);
                        n_fail++;
                    end
                end
            end
            if (mask_left == 0) begin
                case ($urandom_range(0, 3))
                    0: begin
                        ready_mask = 8'hFF;
                    end
                    1: begin
                        ready_mask = 8'h01;
                    end
                    default: begin
                        ready_mask = 8'($urandom) | 8'h01;
                    end
                endcase
                mask_left = $urandom_range(16, 96);
            end else begin
                mask_left--;
            end
            mask_pos = (mask_pos + 1) % 8;
            res_ch.ready <= no_idle ? 1'b1 : ready_mask[mask_pos];
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if (!i_rst_n || (br_ch.valid && br_ch.ready) || (res_ch.valid && res_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic add_branch(input logic [lhbp_pkg::PC_W-1:0] pc, input logic tk,
                              input bit opp);
        t_branch b;
        b.pc      = pc;
        b.taken   = tk;
        b.oppose  = opp;
        pending_q = {pending_q, b};
    endtask

    // mostly loop-shaped and periodic branch streams, some noise
    task automatic add_random(input int count);
        int  done;
        int  len;
        int  reps;
        int  period;
        logic [lhbp_pkg::PC_W-1:0] pc;
        logic [3:0] pattern;
        done = 0;
        while (done < count) begin
            pc = lhbp_pkg::PC_W'($urandom);
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    len  = $urandom_range(2, 10);
                    reps = $urandom_range(2, 6);
                    for (int r = 0; r < reps; r++) begin
                        for (int k = 0; k < len; k++)
                            add_branch(pc, (k != len - 1), 1'b0);
                    end
                    done += len * reps;
                end
                3, 4, 5: begin
                    period  = $urandom_range(2, 4);
                    pattern = 4'($urandom);
                    len     = $urandom_range(8, 30);
                    for (int k = 0; k < len; k++)
                        add_branch(pc, pattern[k % period], 1'b0);
                    done += len;
                end
                default: begin
                    len = $urandom_range(1, 5);
                    for (int k = 0; k < len; k++)
                        add_branch(lhbp_pkg::PC_W'($urandom), 1'($urandom), 1'b0);
                    done += len;
                end
            endcase
        end
    endtask

    task automatic drain();
        do
            @(posedge i_clk);
        while (pending_q.size() != 0 || br_ch.valid || outcome_q.size() != 0);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_entries(input logic [lhbp_pkg::CFG_W-1:0] v);
        @(posedge i_clk);
        cfg_ch.valid          <= 1'b1;
        cfg_ch.entries_in_use <= v;
        do
            @(posedge i_clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        cfg_shadow   = v;
        n_cfg++;
    endtask

    logic [lhbp_pkg::CFG_W-1:0] cfg_plan [7] = '{5'd0, 5'd16, 5'd31, 5'd5, 5'd17, 5'd3, 5'd2};

    initial begin
        i_clk                 = 1'b0;
        i_rst_n               = 1'b0;
        br_ch.valid           = 1'b0;
        br_ch.pc_index        = '0;
        br_ch.taken           = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.entries_in_use = '0;
        res_ch.ready          = 1'b0;
        n_fail                = 0;
        n_items               = 0;
        n_results             = 0;
        n_misses              = 0;
        n_cfg                 = 0;
        idle_cycles           = 0;
        no_idle               = 1'b0;
        cfg_shadow            = lhbp_pkg::CFG_RESET;
        for (int e = 0; e < N_ENTRIES; e++) begin
            hist_mem[e] = '0;
            miss_mem[e] = '0;
            for (int c = 0; c < lhbp_pkg::NUM_CTRS; c++)
                ctr_mem[e][c] = '0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, counter held at both bounds
        add_branch(16'h0000, 1'b0, 1'b0);
        add_branch(16'hFFFF, 1'b1, 1'b0);
        add_branch(16'h0000, 1'b1, 1'b0);
        add_branch(16'hFFFF, 1'b0, 1'b0);
        repeat (12) add_branch(16'h1234, 1'b1, 1'b0);
        repeat (4) add_branch(16'h1234, 1'b0, 1'b0);
        add_branch(16'h8000, 1'b1, 1'b0);
        add_branch(16'h7FFF, 1'b0, 1'b0);
        add_random(PHASE_ITEMS - 22);
        drain();

        // entry count zero, full, above range and in between
        foreach (cfg_plan[k]) begin
            write_entries(cfg_plan[k]);
            add_random(PHASE_ITEMS);
            drain();
        end

        // forced mispredictions on entry 0, back to back
        write_entries(5'd1);
        no_idle = 1'b1;
        repeat (OPPOSE_ITEMS) add_branch(lhbp_pkg::PC_W'($urandom), 1'b0, 1'b1);
        drain();
        no_idle = 1'b0;

        repeat (20) @(posedge i_clk);
        $display("covered %0d branches in %0d entry count settings, %0d predictions checked,",
                 n_items, n_cfg + 1, n_results);
        $display("%0d mispredictions, including a back-to-back run forced on entry 0",
                 n_misses);
        if (n_fail == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/lhbp_pkg.sv
rtl/lhbp_if.sv
rtl/lhbp_ctrl.sv
rtl/lhbp_dp.sv
rtl/local_history_branch_predictor_core.sv
tb/sv/testbench.sv
